// ===== hdl/grdc_pkg.sv =====
// grdc_pkg: shared types, constants and codes of the grid ray caster
// used by every module of the caster; depends on nothing
package grdc_pkg;

  localparam int SCREEN_COLUMNS = 512;
  localparam int MAP_SIDE_DEF   = 32;
  localparam int MAX_STEPS_DEF  = 64;

  localparam int CAM_W   = 25;
  localparam int RAY_W   = 28;
  localparam int PROD_W  = 16 + CAM_W;
  localparam int DVD_W   = 31;
  localparam int DVS_W   = 28;
  localparam int DIST_W  = 24;
  localparam int COORD_W = 11;

  localparam logic [DIST_W-1:0] DIST_MAX = '1;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_CAST  = 1'b1
  } grdc_op_e;

  typedef enum logic [2:0] {
    REG_PLAYER_X       = 3'd0,
    REG_PLAYER_Y       = 3'd1,
    REG_VIEW_DIR_X     = 3'd2,
    REG_VIEW_DIR_Y     = 3'd3,
    REG_CAMERA_PLANE_X = 3'd4,
    REG_CAMERA_PLANE_Y = 3'd5
  } grdc_reg_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RAYMUL,
    ST_RAYSUM,
    ST_DXSTART,
    ST_DXWAIT,
    ST_DYSTART,
    ST_DYWAIT,
    ST_SIDE,
    ST_STEP,
    ST_CHECK,
    ST_DONE
  } grdc_state_e;

  typedef struct packed {
    logic        [15:0] player_x;
    logic        [15:0] player_y;
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic signed [15:0] plane_x;
    logic signed [15:0] plane_y;
  } grdc_cfg_t;

  typedef struct packed {
    grdc_op_e   op;
    logic [8:0] column;
    logic [4:0] cell_x;
    logic [4:0] cell_y;
    logic [7:0] cell_value;
  } grdc_item_t;

  typedef struct packed {
    logic full;
    logic clearing;
  } grdc_status_t;

endpackage

// ===== hdl/grdc_front.sv =====
// grdc_front: configuration registers and input acceptance of the caster
// classifies each accepted item and pushes it to the queue; uses grdc_pkg
module grdc_front (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [2:0]              cfg_index_i,
  input  logic [15:0]             cfg_data_i,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic                    in_operation_i,
  input  logic [8:0]              in_column_i,
  input  logic [4:0]              in_cell_x_i,
  input  logic [4:0]              in_cell_y_i,
  input  logic [7:0]              in_cell_value_i,
  input  grdc_pkg::grdc_status_t  status_i,
  output logic                    push_o,
  output grdc_pkg::grdc_item_t    item_o,
  output grdc_pkg::grdc_cfg_t     cfg_o
);

  grdc_pkg::grdc_cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = status_i.full | status_i.clearing;
  assign push_o      = in_valid_i & ~in_stall_o;

  always_comb begin
    item_o.op         = in_operation_i ? grdc_pkg::OP_CAST : grdc_pkg::OP_WRITE;
    item_o.column     = in_column_i;
    item_o.cell_x     = in_cell_x_i;
    item_o.cell_y     = in_cell_y_i;
    item_o.cell_value = in_cell_value_i;
  end

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (grdc_pkg::grdc_reg_e'(cfg_index_i))
        grdc_pkg::REG_PLAYER_X:       cfg_d.player_x = cfg_data_i;
        grdc_pkg::REG_PLAYER_Y:       cfg_d.player_y = cfg_data_i;
        grdc_pkg::REG_VIEW_DIR_X:     cfg_d.dir_x    = $signed(cfg_data_i);
        grdc_pkg::REG_VIEW_DIR_Y:     cfg_d.dir_y    = $signed(cfg_data_i);
        grdc_pkg::REG_CAMERA_PLANE_X: cfg_d.plane_x  = $signed(cfg_data_i);
        grdc_pkg::REG_CAMERA_PLANE_Y: cfg_d.plane_y  = $signed(cfg_data_i);
        default:                      cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.player_x <= 16'd2048;
      cfg_q.player_y <= 16'd2048;
      cfg_q.dir_x    <= 16'sd16384;
      cfg_q.dir_y    <= 16'sd0;
      cfg_q.plane_x  <= 16'sd0;
      cfg_q.plane_y  <= 16'sd10813;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== hdl/grdc_fifo.sv =====
// grdc_fifo: two-entry queue of classified items between front and back
// uses grdc_pkg for the item type
module grdc_fifo (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  grdc_pkg::grdc_item_t item_i,
  output logic                 full_o,
  input  logic                 pop_i,
  output logic                 valid_o,
  output grdc_pkg::grdc_item_t item_o
);

  grdc_pkg::grdc_item_t slot_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;

  assign full_o  = count_q[1];
  assign valid_o = count_q != 2'd0;
  assign item_o  = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      count_q <= count_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

endmodule

// ===== hdl/grdc_div.sv =====
// grdc_div: restoring divider, one quotient bit per cycle
// used for both delta distances; uses grdc_pkg widths
module grdc_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [grdc_pkg::DVD_W-1:0] dividend_i,
  input  logic [grdc_pkg::DVS_W-1:0] divisor_i,
  output logic                       done_o,
  output logic [grdc_pkg::DVD_W-1:0] quotient_o
);

  localparam int CW = $clog2(grdc_pkg::DVD_W + 1);

  logic [grdc_pkg::DVS_W-1:0] rem_q;
  logic [grdc_pkg::DVS_W-1:0] dvs_q;
  logic [grdc_pkg::DVD_W-1:0] quo_q;
  logic [CW-1:0]              cnt_q;
  logic                       busy_q, done_q;
  logic [grdc_pkg::DVS_W:0]   shifted, trial;
  logic                       fits;

  always_comb begin
    shifted = {rem_q, quo_q[grdc_pkg::DVD_W-1]};
    fits    = shifted >= {1'b0, dvs_q};
    trial   = shifted - {1'b0, dvs_q};
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      dvs_q <= divisor_i;
      quo_q <= dividend_i;
    end else if (busy_q) begin
      rem_q <= fits ? trial[grdc_pkg::DVS_W-1:0] : shifted[grdc_pkg::DVS_W-1:0];
      quo_q <= {quo_q[grdc_pkg::DVD_W-2:0], fits};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(grdc_pkg::DVD_W - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// ===== hdl/grdc_back.sv =====
// grdc_back: map memory with clearing pass, cast sequencer and result register
// depends on grdc_pkg and grdc_div
module grdc_back #(
  parameter int MAP_SIDE  = grdc_pkg::MAP_SIDE_DEF,
  parameter int MAX_STEPS = grdc_pkg::MAX_STEPS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  grdc_pkg::grdc_cfg_t  cfg_i,
  input  logic                 item_valid_i,
  input  grdc_pkg::grdc_item_t item_i,
  output logic                 pop_o,
  output logic                 clearing_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [8:0]           out_result_column_o,
  output logic [23:0]          out_wall_distance_o,
  output logic                 out_hit_side_o,
  output logic [4:0]           out_hit_cell_x_o,
  output logic [4:0]           out_hit_cell_y_o,
  output logic [7:0]           out_hit_value_o,
  output logic                 out_missed_o
);

  localparam int DEPTH  = MAP_SIDE * MAP_SIDE;
  localparam int AW     = $clog2(DEPTH);
  localparam int NW     = $clog2(MAX_STEPS);
  localparam int SIDE_W = 26 + $clog2(MAX_STEPS + 1);
  localparam int CW     = grdc_pkg::COORD_W;
  localparam int DW     = grdc_pkg::DIST_W;

  grdc_pkg::grdc_state_e state_q, state_d;

  logic [7:0]    mem_q [DEPTH];
  logic [7:0]    rdata_q;
  logic [AW-1:0] clr_cnt_q;

  logic [8:0]                           col_q;
  logic signed [grdc_pkg::CAM_W-1:0]    cam_q;
  logic signed [grdc_pkg::PROD_W-1:0]   prod_x_q, prod_y_q;
  logic signed [grdc_pkg::RAY_W-1:0]    rx_q, ry_q;
  logic [DW-1:0]                        dx_q, dy_q;
  logic [SIDE_W-1:0]                    side_x_q, side_y_q;
  logic signed [CW-1:0]                 cx_q, cy_q;
  logic [NW-1:0]                        n_q;
  logic                                 side_q, hit_q;
  logic [7:0]                           val_q;

  logic                                 div_start, div_done;
  logic [grdc_pkg::DVD_W-1:0]           div_dvd, div_quo;
  logic [grdc_pkg::DVS_W-1:0]           div_dvs;
  logic [DW-1:0]                        delta_clip;

  logic                                 we;
  logic [AW-1:0]                        wa;
  logic [7:0]                           wd;
  logic                                 wr_in_map;

  logic                                 step_x;
  logic signed [CW-1:0]                 cx_n, cy_n;
  logic                                 out_map;
  logic [AW-1:0]                        rd_addr;
  logic                                 load_out;
  logic [SIDE_W-1:0]                    dist_wide;
  logic [DW-1:0]                        wall_dist;

  logic out_valid_q;

  grdc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  assign delta_clip = (div_quo > grdc_pkg::DVD_W'(grdc_pkg::DIST_MAX))
                    ? grdc_pkg::DIST_MAX : div_quo[DW-1:0];

  assign wr_in_map = (32'(item_i.cell_x) < MAP_SIDE) && (32'(item_i.cell_y) < MAP_SIDE);

  always_comb begin
    step_x  = side_x_q < side_y_q;
    cx_n    = step_x ? (rx_q < 0 ? cx_q - CW'(1) : cx_q + CW'(1)) : cx_q;
    cy_n    = step_x ? cy_q : (ry_q < 0 ? cy_q - CW'(1) : cy_q + CW'(1));
    out_map = cx_n[CW-1] || cy_n[CW-1]
           || (cx_n >= CW'(MAP_SIDE)) || (cy_n >= CW'(MAP_SIDE));
    rd_addr = AW'(32'(cx_n[6:0]) * MAP_SIDE + 32'(cy_n[6:0]));
  end

  always_comb begin
    dist_wide = side_q ? side_y_q - SIDE_W'(dy_q) : side_x_q - SIDE_W'(dx_q);
    wall_dist = (dist_wide > SIDE_W'(grdc_pkg::DIST_MAX)) ? grdc_pkg::DIST_MAX
              : dist_wide[DW-1:0];
  end

  always_comb begin
    state_d   = state_q;
    pop_o     = 1'b0;
    div_start = 1'b0;
    div_dvd   = grdc_pkg::DVD_W'(1) << 30;
    div_dvs   = '0;
    we        = 1'b0;
    wa        = clr_cnt_q;
    wd        = 8'd0;
    load_out  = 1'b0;
    unique case (state_q)
      grdc_pkg::ST_CLEAR: begin
        we = 1'b1;
        if (clr_cnt_q == AW'(DEPTH - 1)) begin
          state_d = grdc_pkg::ST_IDLE;
        end
      end
      grdc_pkg::ST_IDLE: begin
        if (item_valid_i) begin
          pop_o = 1'b1;
          if (item_i.op == grdc_pkg::OP_WRITE) begin
            we = wr_in_map;
            wa = AW'(32'(item_i.cell_x) * MAP_SIDE + 32'(item_i.cell_y));
            wd = item_i.cell_value;
          end else begin
            state_d = grdc_pkg::ST_RAYMUL;
          end
        end
      end
      grdc_pkg::ST_RAYMUL: state_d = grdc_pkg::ST_RAYSUM;
      grdc_pkg::ST_RAYSUM: state_d = grdc_pkg::ST_DXSTART;
      grdc_pkg::ST_DXSTART: begin
        div_dvs = grdc_pkg::DVS_W'(rx_q < 0 ? -rx_q : rx_q);
        if (rx_q == '0) begin
          state_d = grdc_pkg::ST_DYSTART;
        end else begin
          div_start = 1'b1;
          state_d   = grdc_pkg::ST_DXWAIT;
        end
      end
      grdc_pkg::ST_DXWAIT: if (div_done) state_d = grdc_pkg::ST_DYSTART;
      grdc_pkg::ST_DYSTART: begin
        div_dvs = grdc_pkg::DVS_W'(ry_q < 0 ? -ry_q : ry_q);
        if (ry_q == '0) begin
          state_d = grdc_pkg::ST_SIDE;
        end else begin
          div_start = 1'b1;
          state_d   = grdc_pkg::ST_DYWAIT;
        end
      end
      grdc_pkg::ST_DYWAIT: if (div_done) state_d = grdc_pkg::ST_SIDE;
      grdc_pkg::ST_SIDE:   state_d = grdc_pkg::ST_STEP;
      grdc_pkg::ST_STEP:   state_d = out_map ? grdc_pkg::ST_DONE : grdc_pkg::ST_CHECK;
      grdc_pkg::ST_CHECK: begin
        if (rdata_q != 8'd0 || n_q == NW'(MAX_STEPS - 1)) begin
          state_d = grdc_pkg::ST_DONE;
        end else begin
          state_d = grdc_pkg::ST_STEP;
        end
      end
      grdc_pkg::ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          load_out = 1'b1;
          state_d  = grdc_pkg::ST_IDLE;
        end
      end
      default: state_d = grdc_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= grdc_pkg::ST_CLEAR;
      clr_cnt_q <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == grdc_pkg::ST_CLEAR) begin
        clr_cnt_q <= clr_cnt_q + AW'(1);
      end
    end
  end

  // map memory
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[wa] <= wd;
    end
    if (state_q == grdc_pkg::ST_STEP) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

  // cast datapath
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      grdc_pkg::ST_IDLE: begin
        col_q <= item_i.column;
        cam_q <= $signed(grdc_pkg::CAM_W'({item_i.column, 15'd0}
                                          / 24'(grdc_pkg::SCREEN_COLUMNS)))
               - grdc_pkg::CAM_W'(16384);
      end
      grdc_pkg::ST_RAYMUL: begin
        prod_x_q <= cfg_i.plane_x * cam_q;
        prod_y_q <= cfg_i.plane_y * cam_q;
      end
      grdc_pkg::ST_RAYSUM: begin
        rx_q <= grdc_pkg::RAY_W'(cfg_i.dir_x) + grdc_pkg::RAY_W'(prod_x_q >>> 14);
        ry_q <= grdc_pkg::RAY_W'(cfg_i.dir_y) + grdc_pkg::RAY_W'(prod_y_q >>> 14);
      end
      grdc_pkg::ST_DXSTART: if (rx_q == '0) dx_q <= grdc_pkg::DIST_MAX;
      grdc_pkg::ST_DXWAIT:  if (div_done) dx_q <= delta_clip;
      grdc_pkg::ST_DYSTART: if (ry_q == '0) dy_q <= grdc_pkg::DIST_MAX;
      grdc_pkg::ST_DYWAIT:  if (div_done) dy_q <= delta_clip;
      grdc_pkg::ST_SIDE: begin
        side_x_q <= SIDE_W'((35'(rx_q < 0 ? {1'b0, cfg_i.player_x[9:0]}
                               : 11'd1024 - {1'b0, cfg_i.player_x[9:0]}) * 35'(dx_q)) >> 10);
        side_y_q <= SIDE_W'((35'(ry_q < 0 ? {1'b0, cfg_i.player_y[9:0]}
                               : 11'd1024 - {1'b0, cfg_i.player_y[9:0]}) * 35'(dy_q)) >> 10);
        cx_q  <= CW'(cfg_i.player_x[15:10]);
        cy_q  <= CW'(cfg_i.player_y[15:10]);
        n_q   <= '0;
        hit_q <= 1'b0;
      end
      grdc_pkg::ST_STEP: begin
        if (step_x) begin
          side_x_q <= side_x_q + SIDE_W'(dx_q);
        end else begin
          side_y_q <= side_y_q + SIDE_W'(dy_q);
        end
        side_q <= ~step_x;
        cx_q   <= cx_n;
        cy_q   <= cy_n;
      end
      grdc_pkg::ST_CHECK: begin
        hit_q <= rdata_q != 8'd0;
        val_q <= rdata_q;
        n_q   <= n_q + NW'(1);
      end
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_result_column_o <= col_q;
      out_wall_distance_o <= hit_q ? wall_dist : grdc_pkg::DIST_MAX;
      out_hit_side_o      <= hit_q & side_q;
      out_hit_cell_x_o    <= hit_q ? cx_q[4:0] : 5'd0;
      out_hit_cell_y_o    <= hit_q ? cy_q[4:0] : 5'd0;
      out_hit_value_o     <= hit_q ? val_q : 8'd0;
      out_missed_o        <= ~hit_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign clearing_o  = state_q == grdc_pkg::ST_CLEAR;

endmodule

// ===== hdl/grid_ray_dda_caster.sv =====
// grid_ray_dda_caster: top level of the grid DDA ray caster
// instantiates grdc_front, grdc_fifo and grdc_back; uses grdc_pkg
//
// After reset all MAP_SIDE*MAP_SIDE map cells (1024 by default) are cleared, during
// which in_stall_o is high; configuration registers should only be written while no item
// is in flight. A cell write is made as the item is picked up. The camera offset is a
// shift taken when the cast is picked up; a cast then passes the ray multiply and sum
// (ST_RAYMUL, ST_RAYSUM), finds each nonzero ray component's delta distance on the
// shared one-bit-per-cycle divider (a zero component skips the divider), sets up in
// ST_SIDE, takes each map step through ST_STEP (map read) and ST_CHECK, and loads the
// result in ST_DONE. A cast makes at most MAX_STEPS map steps, and ST_DONE waits while
// the result register is stalled. A two-entry queue takes new items while a cast runs,
// and the result register holds a finished result while the next item starts.
module grid_ray_dda_caster #(
  parameter int MAP_SIDE  = grdc_pkg::MAP_SIDE_DEF,
  parameter int MAX_STEPS = grdc_pkg::MAX_STEPS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        in_operation_i,
  input  logic [8:0]  in_column_i,
  input  logic [4:0]  in_cell_x_i,
  input  logic [4:0]  in_cell_y_i,
  input  logic [7:0]  in_cell_value_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [8:0]  out_result_column_o,
  output logic [23:0] out_wall_distance_o,
  output logic        out_hit_side_o,
  output logic [4:0]  out_hit_cell_x_o,
  output logic [4:0]  out_hit_cell_y_o,
  output logic [7:0]  out_hit_value_o,
  output logic        out_missed_o
);

  grdc_pkg::grdc_status_t status;
  grdc_pkg::grdc_item_t   push_item, pop_item;
  grdc_pkg::grdc_cfg_t    cfg;
  logic                   push, pop, q_valid, q_full, clearing;

  assign status.full     = q_full;
  assign status.clearing = clearing;

  grdc_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .in_operation_i  (in_operation_i),
    .in_column_i     (in_column_i),
    .in_cell_x_i     (in_cell_x_i),
    .in_cell_y_i     (in_cell_y_i),
    .in_cell_value_i (in_cell_value_i),
    .status_i        (status),
    .push_o          (push),
    .item_o          (push_item),
    .cfg_o           (cfg)
  );

  grdc_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .item_o  (pop_item)
  );

  grdc_back #(
    .MAP_SIDE  (MAP_SIDE),
    .MAX_STEPS (MAX_STEPS)
  ) u_back (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_i               (cfg),
    .item_valid_i        (q_valid),
    .item_i              (pop_item),
    .pop_o               (pop),
    .clearing_o          (clearing),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .out_result_column_o (out_result_column_o),
    .out_wall_distance_o (out_wall_distance_o),
    .out_hit_side_o      (out_hit_side_o),
    .out_hit_cell_x_o    (out_hit_cell_x_o),
    .out_hit_cell_y_o    (out_hit_cell_y_o),
    .out_hit_value_o     (out_hit_value_o),
    .out_missed_o        (out_missed_o)
  );

endmodule

// ===== hdl/grdc_checker.sv =====
// grdc_checker: port-level assertions for the grid ray caster
// bound to grid_ray_dda_caster; depends on nothing else
module grdc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [23:0] out_wall_distance_o,
  input logic        out_hit_side_o,
  input logic [7:0]  out_hit_value_o,
  input logic        out_missed_o
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_wall_distance_o))
    else $error("stalled result changed");

  // miss gives largest distance, zero hit value and no hit side
  a_miss_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_missed_o |->
      out_wall_distance_o == 24'hFFFFFF && out_hit_value_o == 8'd0 && !out_hit_side_o)
    else $error("miss result has hit fields");

  // a hit always reports a nonempty cell
  a_hit_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_missed_o |-> out_hit_value_o != 8'd0)
    else $error("hit with empty cell");

  // map clearing blocks input right after reset
  a_clear_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(rst_ni) |-> in_stall_o)
    else $error("input taken during map clear");

endmodule

bind grid_ray_dda_caster grdc_checker u_grdc_checker (
  .clk_i               (clk_i),
  .rst_ni              (rst_ni),
  .in_stall_o          (in_stall_o),
  .out_valid_o         (out_valid_o),
  .out_stall_i         (out_stall_i),
  .out_wall_distance_o (out_wall_distance_o),
  .out_hit_side_o      (out_hit_side_o),
  .out_hit_value_o     (out_hit_value_o),
  .out_missed_o        (out_missed_o)
);

// ===== sim/grdc_cast_checker.sv =====
// grdc_cast_checker: watches the config, item and result channels of the caster,
// predicts every cast result from its own map and register copy and compares them
// depends on grdc_pkg
`timescale 1ns / 1ps

module grdc_cast_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic        in_operation_i,
  input  logic [8:0]  in_column_i,
  input  logic [4:0]  in_cell_x_i,
  input  logic [4:0]  in_cell_y_i,
  input  logic [7:0]  in_cell_value_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [8:0]  out_result_column_i,
  input  logic [23:0] out_wall_distance_i,
  input  logic        out_hit_side_i,
  input  logic [4:0]  out_hit_cell_x_i,
  input  logic [4:0]  out_hit_cell_y_i,
  input  logic [7:0]  out_hit_value_i,
  input  logic        out_missed_i,
  output int          errors_o,
  output int          pending_o
);

  localparam int SIDE  = grdc_pkg::MAP_SIDE_DEF;
  localparam int STEPS = grdc_pkg::MAX_STEPS_DEF;
  localparam longint unsigned DMAX = 64'hFF_FFFF;

  typedef struct packed {
    logic [8:0]  column;
    logic [23:0] distance;
    logic        side;
    logic [4:0]  hit_x;
    logic [4:0]  hit_y;
    logic [7:0]  value;
    logic        missed;
  } wall_hit_t;

  grdc_pkg::grdc_cfg_t cfg_q;
  logic [7:0] map_q [SIDE*SIDE];
  wall_hit_t  hits_q [$];

  assign pending_o = hits_q.size();

  function automatic longint unsigned axis_delta(longint r);
    longint unsigned mag;
    longint unsigned d;
    if (r == 0) return DMAX;
    mag = (r < 0) ? longint'(-r) : longint'(r);
    d = (64'd1 << 30) / mag;
    return (d > DMAX) ? DMAX : d;
  endfunction

  function automatic wall_hit_t trace_ray(logic [8:0] col);
    longint cam, rx, ry, cx, cy, sx, sy;
    longint unsigned dx, dy, fx, fy, side_x, side_y, d;
    logic [7:0] val;
    bit hit, side;
    wall_hit_t r;
    cam = (longint'(col) * 2 * 16384) / grdc_pkg::SCREEN_COLUMNS - 16384;
    rx = longint'($signed(cfg_q.dir_x)) + ((longint'($signed(cfg_q.plane_x)) * cam) >>> 14);
    ry = longint'($signed(cfg_q.dir_y)) + ((longint'($signed(cfg_q.plane_y)) * cam) >>> 14);
    cx = longint'(cfg_q.player_x >> 10);
    cy = longint'(cfg_q.player_y >> 10);
    fx = cfg_q.player_x & 16'h3FF;
    fy = cfg_q.player_y & 16'h3FF;
    dx = axis_delta(rx);
    dy = axis_delta(ry);
    if (rx < 0) begin
      sx = -1; side_x = (fx * dx) >> 10;
    end else begin
      sx = 1;  side_x = ((1024 - fx) * dx) >> 10;
    end
    if (ry < 0) begin
      sy = -1; side_y = (fy * dy) >> 10;
    end else begin
      sy = 1;  side_y = ((1024 - fy) * dy) >> 10;
    end
    hit = 0;
    side = 0;
    val = '0;
    for (int n = 0; n < STEPS; n++) begin
      if (side_x < side_y) begin
        side_x += dx; cx += sx; side = 0;
      end else begin
        side_y += dy; cy += sy; side = 1;
      end
      if (cx < 0 || cy < 0 || cx >= SIDE || cy >= SIDE) break;
      val = map_q[cx*SIDE + cy];
      if (val != 0) begin
        hit = 1;
        break;
      end
    end
    r = '0;
    r.column = col;
    if (hit) begin
      d = side ? side_y - dy : side_x - dx;
      r.distance = (d > DMAX) ? grdc_pkg::DIST_MAX : d[23:0];
      r.side     = side;
      r.hit_x    = cx[4:0];
      r.hit_y    = cy[4:0];
      r.value    = val;
    end else begin
      r.distance = grdc_pkg::DIST_MAX;
      r.missed   = 1'b1;
    end
    return r;
  endfunction

  task automatic report(string what, longint got, longint want);
    $display("%0t mismatch %s: got %0d expected %0d", $time, what, got, want);
    errors_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    wall_hit_t w;
    if (!rst_ni) begin
      cfg_q <= '{player_x: 16'd2048, player_y: 16'd2048, dir_x: 16'sd16384,
                 dir_y: 16'sd0, plane_x: 16'sd0, plane_y: 16'sd10813};
      for (int i = 0; i < SIDE*SIDE; i++) map_q[i] = '0;
      hits_q.delete();
      errors_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (grdc_pkg::grdc_reg_e'(cfg_index_i))
          grdc_pkg::REG_PLAYER_X:       cfg_q.player_x <= cfg_data_i;
          grdc_pkg::REG_PLAYER_Y:       cfg_q.player_y <= cfg_data_i;
          grdc_pkg::REG_VIEW_DIR_X:     cfg_q.dir_x    <= cfg_data_i;
          grdc_pkg::REG_VIEW_DIR_Y:     cfg_q.dir_y    <= cfg_data_i;
          grdc_pkg::REG_CAMERA_PLANE_X: cfg_q.plane_x  <= cfg_data_i;
          grdc_pkg::REG_CAMERA_PLANE_Y: cfg_q.plane_y  <= cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        if (grdc_pkg::grdc_op_e'(in_operation_i) == grdc_pkg::OP_WRITE) begin
          map_q[in_cell_x_i*SIDE + in_cell_y_i] = in_cell_value_i;
        end else begin
          hits_q.push_back(trace_ray(in_column_i));
        end
      end
      if (out_valid_i && !out_stall_i) begin
        if (hits_q.size() == 0) begin
          report("unexpected result, column", out_result_column_i, -1);
        end else begin
          w = hits_q.pop_front();
          if (out_result_column_i != w.column) report("column", out_result_column_i, w.column);
          if (out_wall_distance_i != w.distance)
            report("distance", out_wall_distance_i, w.distance);
          if (out_hit_side_i != w.side) report("side", out_hit_side_i, w.side);
          if (out_hit_cell_x_i != w.hit_x) report("cell x", out_hit_cell_x_i, w.hit_x);
          if (out_hit_cell_y_i != w.hit_y) report("cell y", out_hit_cell_y_i, w.hit_y);
          if (out_hit_value_i != w.value) report("value", out_hit_value_i, w.value);
          if (out_missed_i != w.missed) report("missed", out_missed_i, w.missed);
        end
      end
    end
  end

endmodule

// ===== sim/grid_ray_dda_caster_tb.sv =====
// grid_ray_dda_caster_tb: drives map writes, casts and register settings into the
// caster with random gaps and stalls; grdc_cast_checker does the checking
// depends on grdc_pkg, grid_ray_dda_caster and grdc_cast_checker
`timescale 1ns / 1ps

module grid_ray_dda_caster_tb;

  localparam int QUIET_LIMIT = 12000;
  localparam int SETTLE      = 300;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i = '0;
  logic [15:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic        in_operation_i = 1'b0;
  logic [8:0]  in_column_i = '0;
  logic [4:0]  in_cell_x_i = '0;
  logic [4:0]  in_cell_y_i = '0;
  logic [7:0]  in_cell_value_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [8:0]  out_result_column_o;
  logic [23:0] out_wall_distance_o;
  logic        out_hit_side_o;
  logic [4:0]  out_hit_cell_x_o;
  logic [4:0]  out_hit_cell_y_o;
  logic [7:0]  out_hit_value_o;
  logic        out_missed_o;

  int errors;
  int pending;
  int quiet_cycles;
  int stall_left;
  bit calm;

  always #2 clk_i = ~clk_i;

  grid_ray_dda_caster dut (.*);

  grdc_cast_checker checker_i (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_stall_i(in_stall_o), .in_operation_i, .in_column_i, .in_cell_x_i,
    .in_cell_y_i, .in_cell_value_i, .out_valid_i(out_valid_o), .out_stall_i,
    .out_result_column_i(out_result_column_o), .out_wall_distance_i(out_wall_distance_o),
    .out_hit_side_i(out_hit_side_o), .out_hit_cell_x_i(out_hit_cell_x_o),
    .out_hit_cell_y_i(out_hit_cell_y_o), .out_hit_value_i(out_hit_value_o),
    .out_missed_i(out_missed_o), .errors_o(errors), .pending_o(pending)
  );

  // result side backpressure
  always @(posedge clk_i or negedge rst_ni) begin
    int r;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left  <= 0;
    end else if (stall_left > 0) begin
      stall_left  <= stall_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      r = $urandom_range(0, 99);
      out_stall_i <= 1'b0;
      if (!calm && r < 25) begin
        stall_left  <= (r < 3) ? $urandom_range(10, 60) : $urandom_range(0, 3);
        out_stall_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic write_reg(grdc_pkg::grdc_reg_e idx, logic [15:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_view(logic [15:0] px, logic [15:0] py, logic [15:0] dx,
                          logic [15:0] dy, logic [15:0] cx, logic [15:0] cy);
    write_reg(grdc_pkg::REG_PLAYER_X, px);
    write_reg(grdc_pkg::REG_PLAYER_Y, py);
    write_reg(grdc_pkg::REG_VIEW_DIR_X, dx);
    write_reg(grdc_pkg::REG_VIEW_DIR_Y, dy);
    write_reg(grdc_pkg::REG_CAMERA_PLANE_X, cx);
    write_reg(grdc_pkg::REG_CAMERA_PLANE_Y, cy);
  endtask

  task automatic drain;
    in_valid_i <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic send(grdc_pkg::grdc_op_e op, logic [8:0] col, logic [4:0] x, logic [4:0] y,
                      logic [7:0] v, bit gaps);
    int r;
    int n;
    in_valid_i      <= 1'b1;
    in_operation_i  <= op;
    in_column_i     <= col;
    in_cell_x_i     <= x;
    in_cell_y_i     <= y;
    in_cell_value_i <= v;
    do @(posedge clk_i); while (in_stall_o);
    r = $urandom_range(0, 99);
    n = 0;
    if (gaps && r >= 60) n = (r < 93) ? $urandom_range(1, 3) : $urandom_range(10, 60);
    if (n > 0) begin
      in_valid_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  task automatic random_items(int count, bit gaps);
    int r;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < 30)
        send(grdc_pkg::OP_WRITE, 9'($urandom), 5'($urandom), 5'($urandom),
             (r < 12) ? 8'd0 : 8'($urandom_range(1, 255)), gaps);
      else
        send(grdc_pkg::OP_CAST, 9'($urandom), 5'($urandom), 5'($urandom), 8'($urandom),
             gaps);
    end
  endtask

  initial begin
    int r;
    calm = 1'b1;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty map, walls at corners, under the player and ahead of it
    send(grdc_pkg::OP_CAST, 9'd256, 5'd0, 5'd0, 8'd0, 0);
    send(grdc_pkg::OP_WRITE, 9'd0, 5'd31, 5'd31, 8'd255, 0);
    send(grdc_pkg::OP_WRITE, 9'd0, 5'd0, 5'd0, 8'd1, 0);
    send(grdc_pkg::OP_WRITE, 9'd0, 5'd2, 5'd2, 8'd7, 0);
    send(grdc_pkg::OP_WRITE, 9'd0, 5'd10, 5'd2, 8'd128, 0);
    send(grdc_pkg::OP_CAST, 9'd256, 5'd0, 5'd0, 8'd0, 0);
    send(grdc_pkg::OP_CAST, 9'd0, 5'd0, 5'd0, 8'd0, 0);
    send(grdc_pkg::OP_CAST, 9'd511, 5'd0, 5'd0, 8'd0, 0);
    send(grdc_pkg::OP_WRITE, 9'd0, 5'd10, 5'd2, 8'd0, 0);
    send(grdc_pkg::OP_CAST, 9'd255, 5'd0, 5'd0, 8'd0, 0);
    drain();
    // zero ray component on y, then on x, and a diagonal into the far corner
    set_view(16'd2600, 16'd2048, 16'd16384, 16'd0, 16'd0, 16'd0);
    send(grdc_pkg::OP_CAST, 9'd100, 5'd0, 5'd0, 8'd0, 0);
    drain();
    set_view(16'd2048, 16'd700, 16'd0, -16'sd16384, 16'd0, 16'd0);
    send(grdc_pkg::OP_CAST, 9'd0, 5'd0, 5'd0, 8'd0, 0);
    drain();
    set_view(16'd512, 16'd512, 16'd11585, 16'd11585, -16'sd7000, 16'd7000);
    send(grdc_pkg::OP_CAST, 9'd256, 5'd0, 5'd0, 8'd0, 0);
    send(grdc_pkg::OP_CAST, 9'd511, 5'd0, 5'd0, 8'd0, 0);
    drain();
    // extremes: player far outside the map and at its origin, largest vectors
    set_view(16'hFFFF, 16'hFFFF, -16'sd32768, 16'sd32767, 16'sd32767, -16'sd32768);
    send(grdc_pkg::OP_CAST, 9'd0, 5'd0, 5'd0, 8'd0, 0);
    send(grdc_pkg::OP_CAST, 9'd511, 5'd0, 5'd0, 8'd0, 0);
    drain();
    set_view(16'd0, 16'd0, 16'sd32767, -16'sd32768, -16'sd32768, 16'sd32767);
    send(grdc_pkg::OP_CAST, 9'd0, 5'd0, 5'd0, 8'd0, 0);
    send(grdc_pkg::OP_CAST, 9'd300, 5'd0, 5'd0, 8'd0, 0);
    drain();

    for (int phase = 0; phase < 9; phase++) begin
      calm = (phase == 2);
      r = $urandom_range(0, 99);
      if (r < 80)
        set_view(16'($urandom_range(0, 32767)), 16'($urandom_range(0, 32767)),
                 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
      else
        set_view(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                 16'($urandom), 16'($urandom));
      random_items(150, phase != 3);
      drain();
    end

    calm = 1'b1;
    if (errors == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
